// ===== rtl/eppm_pkg.sv =====
package eppm_pkg;
   localparam int PacketBytes  = 33;
   localparam int FractionBits = 24;
   localparam int StoreSize    = 30;
   localparam int ValueWidth   = 48;

   localparam logic [7:0] StartMark = 8'hA0;
   localparam logic [7:0] EndPlain  = 8'hC0;
   localparam logic [7:0] EndAnalog = 8'hC1;
   localparam logic [7:0] EndTop    = 8'hC6;

   localparam logic CsrEegGain   = 1'b0;
   localparam logic CsrAccelGain = 1'b1;

   typedef logic signed [ValueWidth-1:0] value_type;

   function automatic value_type to_fixed(input logic signed [16:0] v);
      value_type w;
      w = value_type'(v);
      return w <<< FractionBits;
   endfunction

   function automatic value_type halve_sum(input value_type a, input value_type b);
      logic signed [ValueWidth:0] s;
      s = {a[ValueWidth-1], a} + {b[ValueWidth-1], b};
      return s[ValueWidth:1];
   endfunction
endpackage

// ===== rtl/eppm_buffer.sv =====
module eppm_buffer
   import eppm_pkg::*;
(
   input  logic       clock,
   input  logic       wr_en,
   input  logic [5:0] wr_addr,
   input  logic [7:0] wr_data,
   input  logic [5:0] rd_addr,
   output logic [7:0] rd_data
);
   logic [7:0] mem [PacketBytes];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/eeg_packet_pair_merger.sv =====
// EEG packet pair merger. Datagram bytes arrive one per req beat (tdata byte, tlast on the
// final byte) and are accepted only while idle. Bytes go into a 33-entry buffer memory.
// When a good 33-byte datagram ends, req is held off and a sequencer reads the datagram back
// out of the buffer: first the id, then eight EEG words (three reads and the gain multiply
// each), six aux bytes and three accel/analog words. The second packet of a pair then streams
// all 30 sample store entries out of the store memory, one entry at a time (store read, then
// output register), tlast on channel 29. Back-pressure on rsp stretches this. req stays held
// off until the last channel is in the output register. After reset a clearing pass writes
// zero to every store entry before the first byte is taken.
module eeg_packet_pair_merger
   import eppm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // datagram_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [4:0] channel_index, [52:5] channel_value, zero fill
   output logic        rsp_tlast,   // last_channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [23:0] csr_data
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HDR, S_EEG, S_EEGMUL, S_AUXRD, S_AUX, S_ACC, S_ACCMUL,
      S_EMIT
   } state_type;

   state_type   state_ff;
   logic [23:0] eeg_gain_ff, accel_gain_ff;
   logic [5:0]  byte_count_ff;
   logic [7:0]  last_id_ff, endb_ff, first_b_ff;
   logic        first_flag_ff, first_cur_ff, accx_nz_ff;
   logic [5:0]  rd_addr_ff;
   logic [4:0]  step_ff;
   logic [23:0] word_ff;
   logic [1:0]  bcnt_ff;
   logic signed [48:0] prod_ff;
   value_type   acc_hold_ff [3];
   // sample store memory with one write and one registered read port
   value_type   store [StoreSize];
   value_type   st_rd_ff;
   logic        st_we;
   logic [4:0]  st_wa, st_ra;
   value_type   st_wd;
   logic [4:0]  out_idx_ff;
   logic        out_valid_ff, out_last_ff;
   value_type   out_val_ff;
   logic        emit_rd_ff;
   logic [4:0]  emit_idx_ff;
   logic [4:0]  rd_cnt_ff;
   logic [7:0]  buf_rd;

   wire req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eeg_gain_ff <= '0;
         accel_gain_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CsrEegGain) eeg_gain_ff <= csr_data;
         else accel_gain_ff <= csr_data;
      end
   end

   eppm_buffer u_buf (
      .clock  (clock),
      .wr_en  (req_fire && byte_count_ff < 6'(PacketBytes)),
      .wr_addr(byte_count_ff),
      .wr_data(req_tdata),
      .rd_addr(rd_addr_ff),
      .rd_data(buf_rd)
   );

   always_ff @(posedge clock) begin
      if (st_we) store[st_wa] <= st_wd;
      st_rd_ff <= store[st_ra];
   end

   // datagram check of the byte just completing
   wire good = req_tlast && byte_count_ff == 6'(PacketBytes - 1) && first_b_ff == StartMark
               && req_tdata >= EndPlain && req_tdata <= EndTop;

   // id is on buf_rd in the header step with bcnt_ff at one
   wire hdr_first = (buf_rd != last_id_ff) || first_flag_ff;

   wire signed [16:0] w16   = $signed({word_ff[15], word_ff[15:0]});

   always_comb begin
      st_we = 1'b0;
      st_wa = step_ff;
      st_wd = '0;
      st_ra = step_ff;
      unique case (state_ff)
         S_CLEAR: st_we = 1'b1;
         S_HDR: begin
            st_we = (bcnt_ff == 2'd1);
            st_wa = hdr_first ? 5'd0 : 5'd20;
            st_wd = to_fixed(17'(hdr_first ? buf_rd : endb_ff));
         end
         S_EEGMUL: begin
            st_we = 1'b1;
            st_wa = 5'(step_ff + (first_cur_ff ? 5'd1 : 5'd9));
            st_wd = prod_ff[47:0];
         end
         S_AUX: begin
            st_we = 1'b1;
            st_wa = 5'(21 + step_ff);
            st_wd = first_cur_ff ? to_fixed(17'(buf_rd))
                                 : halve_sum(st_rd_ff, to_fixed(17'(buf_rd)));
         end
         S_AUXRD: st_ra = 5'(21 + step_ff);
         S_ACC: st_ra = 5'(27 + step_ff);
         S_ACCMUL: begin
            st_we = (endb_ff == EndPlain) || (endb_ff == EndAnalog);
            if (endb_ff == EndPlain) begin
               st_wa = 5'(17 + step_ff);
               st_wd = (accx_nz_ff) ? (first_cur_ff ? prod_ff[47:0]
                       : halve_sum(acc_hold_ff[step_ff[1:0]], prod_ff[47:0]))
                       : acc_hold_ff[step_ff[1:0]];
            end else begin
               st_wa = 5'(27 + step_ff);
               st_wd = first_cur_ff ? to_fixed(w16) : halve_sum(st_rd_ff, to_fixed(w16));
            end
         end
         // hold the read address while a word waits for the output register
         S_EMIT: st_ra = emit_rd_ff ? emit_idx_ff : rd_cnt_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         step_ff <= '0;
         byte_count_ff <= '0;
         last_id_ff <= '0;
         first_flag_ff <= 1'b1;
         out_valid_ff <= 1'b0;
         emit_rd_ff <= 1'b0;
         rd_cnt_ff <= '0;
         for (int i = 0; i < 3; i++) acc_hold_ff[i] <= '0;
      end else begin
         if (rsp_tvalid && rsp_tready && !(state_ff == S_EMIT && emit_rd_ff))
            out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               step_ff <= 5'(step_ff + 1);
               if (step_ff == 5'(StoreSize - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: if (req_fire) begin
               if (byte_count_ff == '0) first_b_ff <= req_tdata;
               if (req_tlast) begin
                  byte_count_ff <= '0;
                  if (good) begin
                     endb_ff <= req_tdata;
                     rd_addr_ff <= 6'd1;
                     bcnt_ff <= '0;
                     step_ff <= '0;
                     state_ff <= S_HDR;
                  end
               end else if (byte_count_ff <= 6'(PacketBytes)) begin
                  byte_count_ff <= byte_count_ff + 6'd1;
               end
            end
            S_HDR: begin
               // buf_rd valid in the cycle after rd_addr=1
               if (bcnt_ff == 2'd0) begin
                  bcnt_ff <= 2'd1;
                  rd_addr_ff <= 6'd2;
               end else begin
                  first_cur_ff <= hdr_first;
                  last_id_ff <= buf_rd;
                  bcnt_ff <= 2'd0;
                  rd_addr_ff <= 6'd2;
                  state_ff <= S_EEG;
               end
            end
            S_EEG: begin
               // collect three bytes, reads pipelined
               if (bcnt_ff != 2'd0) word_ff <= {word_ff[15:0], buf_rd};
               if (bcnt_ff == 2'd3) begin
                  bcnt_ff <= 2'd0;
                  state_ff <= S_EEGMUL;
               end else begin
                  bcnt_ff <= bcnt_ff + 2'd1;
                  if (bcnt_ff != 2'd2) rd_addr_ff <= rd_addr_ff + 6'd1;
               end
               if (bcnt_ff == 2'd2) rd_addr_ff <= rd_addr_ff + 6'd1;
            end
            S_EEGMUL: ;
            S_AUXRD: begin
               state_ff <= S_AUX;
            end
            S_AUX: begin
               if (step_ff == 5'd5) begin
                  step_ff <= '0;
                  rd_addr_ff <= 6'd26;
                  bcnt_ff <= '0;
                  state_ff <= S_ACC;
               end else begin
                  step_ff <= 5'(step_ff + 1);
                  rd_addr_ff <= rd_addr_ff + 6'd1;
                  state_ff <= S_AUXRD;
               end
            end
            S_ACC: begin
               if (bcnt_ff != 2'd0) word_ff <= {word_ff[15:0], buf_rd};
               if (bcnt_ff == 2'd2) begin
                  bcnt_ff <= 2'd0;
                  state_ff <= S_ACCMUL;
               end else begin
                  bcnt_ff <= bcnt_ff + 2'd1;
                  if (bcnt_ff == 2'd0) rd_addr_ff <= rd_addr_ff + 6'd1;
               end
            end
            S_ACCMUL: begin
               if (endb_ff == EndPlain) begin
                  if (accx_nz_ff) acc_hold_ff[step_ff[1:0]] <= st_wd;
               end
               rd_addr_ff <= rd_addr_ff + 6'd1;
               if (step_ff == 5'd2) begin
                  first_flag_ff <= 1'b0;
                  if (!first_cur_ff) begin
                     rd_cnt_ff <= '0;
                     emit_rd_ff <= 1'b0;
                     state_ff <= S_EMIT;
                  end else state_ff <= S_IDLE;
                  step_ff <= '0;
               end else begin
                  step_ff <= 5'(step_ff + 1);
                  state_ff <= S_ACC;
               end
            end
            S_EMIT: begin
               // one read in flight; output register takes it when free
               if (!out_valid_ff || rsp_tready) begin
                  if (emit_rd_ff) begin
                     out_valid_ff <= 1'b1;
                     out_val_ff <= st_rd_ff;
                     out_idx_ff <= emit_idx_ff;
                     out_last_ff <= (emit_idx_ff == 5'(StoreSize - 1));
                     emit_rd_ff <= 1'b0;
                     if (emit_idx_ff == 5'(StoreSize - 1)) state_ff <= S_IDLE;
                  end else begin
                     emit_rd_ff <= 1'b1;
                     emit_idx_ff <= rd_cnt_ff;
                     rd_cnt_ff <= 5'(rd_cnt_ff + 1);
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         // EEG word index tracking, EEG and accel products and X-nonzero flag
         if (state_ff == S_EEGMUL) begin
            if (step_ff == 5'd7) begin
               step_ff <= '0;
               rd_addr_ff <= 6'd26;
               state_ff <= S_AUXRD;
            end else begin
               step_ff <= 5'(step_ff + 1);
               bcnt_ff <= '0;
               state_ff <= S_EEG;
            end
         end
         if (state_ff == S_EEG && bcnt_ff == 2'd3)
            prod_ff <= 49'($signed({1'b0, eeg_gain_ff})
                           * $signed({word_ff[15], word_ff[15:0], buf_rd}));
         if (state_ff == S_ACC && bcnt_ff == 2'd2) begin
            prod_ff <= 49'($signed({1'b0, accel_gain_ff})
                           * $signed({{9{word_ff[7]}}, word_ff[7:0], buf_rd}));
            if (step_ff == 5'd0) accx_nz_ff <= ({word_ff[7:0], buf_rd} != 16'h0000);
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_val_ff, out_idx_ff};
   assign rsp_tlast  = out_last_ff;
endmodule
